>>> rtl/rps_pkg.sv
// ----------------------------------------------------------------------------
// rps_pkg
// Shared types and constants for the reflow profile sequencer.
// ----------------------------------------------------------------------------
package rps_pkg;

    localparam int MAX_STEPS_DEF = 6;
    localparam int TPS_DEF       = 1000;

    // Register map
    localparam int NUM_CFG_STEPS = 6;
    localparam int CFG_ADDR_W    = 6;
    localparam int CFG_DATA_W    = 64;
    localparam logic [2:0] REG_STEP_COUNT = 3'd6;

    localparam int TEMP_W    = 12;
    localparam int ELAPSED_W = 27;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    // Request kinds on the input stream
    localparam logic [1:0] REQ_TICK    = 2'd0;
    localparam logic [1:0] REQ_START   = 2'd1;
    localparam logic [1:0] REQ_ADVANCE = 2'd2;

    // One profile step, same bit layout as the step registers
    typedef struct packed {
        logic [15:0]       hold;
        logic [7:0]        rate;
        logic [TEMP_W-1:0] target;
    } t_step;

    typedef struct packed {
        logic [2:0]                     count;
        t_step [NUM_CFG_STEPS-1:0]      step;
    } t_cfg;

    localparam logic [35:0] STEP0_RST = 36'd31523216;
    localparam logic [35:0] STEP1_RST = 36'd63046352;
    localparam logic [2:0]  COUNT_RST = 3'd2;
    localparam logic [2:0]  PRESET_LEN = 3'd3;

    function automatic t_step preset_step(input logic [2:0] idx);
        t_step s;
        s = '0;
        case (idx)
            3'd0: begin
                s.target = 12'd600;
                s.rate   = 8'd16;
                s.hold   = 16'd60;
            end
            3'd1: begin
                s.target = 12'd920;
                s.rate   = 8'd32;
                s.hold   = 16'd30;
            end
            3'd2: begin
                s.target = 12'd100;
                s.rate   = 8'd32;
                s.hold   = 16'd0;
            end
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

>>> rtl/reflow_profile_sequencer.sv
// ----------------------------------------------------------------------------
// reflow_profile_sequencer
// Walks a heater through a temperature profile with on/off control.
// ----------------------------------------------------------------------------
// Channel      | Direction | Handshake                | Carries
// s_axis       | in        | tvalid/tready            | tick, start or advance request
// m_axis       | out       | tvalid/tready            | heater, setpoint, phase, step, temp
// APB          | in        | psel/penable, pready = 1 | step table and step count
//
// A request is held in the input register and then resolved into the output
// register; one request per cycle is sustained while the output is not stalled.
// The ramp offset is kept as a running quotient/remainder of rate*elapsed/
// (4*ticks) so no divider sits in the path. Reset is synchronous.
// The input register keeps accepting while a result waits in the output
// register; a stalled output backs up into the input only once both are full.
// ----------------------------------------------------------------------------
module reflow_profile_sequencer import rps_pkg::*; #(
    parameter int MAX_MANUAL_STEPS = MAX_STEPS_DEF,
    parameter int TICKS_PER_SECOND = TPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [11:0] temp_sample, [12] sample_valid, [13] use_manual, [14] auto_advance
    input  logic [15:0]           s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] heater_on, [12:1] setpoint, [14:13] phase, [17:15] step_number,
    // [29:18] temperature
    output logic [31:0]           m_axis_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic                  pready,
    output logic [CFG_DATA_W-1:0] prdata
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_RAMP = 2'd1,
        PH_HOLD = 2'd2,
        PH_WAIT = 2'd3
    } t_phase;

    localparam int DIV      = 4 * TICKS_PER_SECOND;
    localparam int RW       = $clog2(DIV);
    localparam int QW       = 13;
    localparam int TPS_W    = $clog2(TICKS_PER_SECOND + 1);
    localparam int HW       = 16 + TPS_W;
    localparam int CW       = (HW > ELAPSED_W) ? HW : ELAPSED_W;
    localparam logic [RW:0]   DIV_W   = (RW + 1)'(DIV);
    localparam logic [QW:0]   Q_SAT   = (QW + 1)'(4096);
    localparam logic [2:0]    MAX_W   = 3'(MAX_MANUAL_STEPS);
    localparam logic [TPS_W-1:0] TPS_V = TPS_W'(TICKS_PER_SECOND);

    t_cfg cfg;

    rps_cfg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .pready  (pready),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    // rate / DIV and rate % DIV for every 8-bit rate, settled at elaboration
    logic [7:0]    rate_q_tbl [256];
    logic [RW-1:0] rate_r_tbl [256];

    for (genvar k = 0; k < 256; k++) begin : g_rate_tbl
        localparam int KQ = k / DIV;
        localparam int KR = k % DIV;
        assign rate_q_tbl[k] = 8'(KQ);
        assign rate_r_tbl[k] = RW'(KR);
    end

    // Input register
    logic        r_in_valid;
    logic [1:0]  r_in_req;
    logic [11:0] r_in_sample;
    logic        r_in_sv;
    logic        r_in_man;
    logic        r_in_auto;

    // Sequencer state
    t_phase            r_phase, n_phase;
    logic [2:0]        r_step, n_step;
    logic [2:0]        r_len, n_len;
    logic              r_man, n_man;
    logic              r_auto, n_auto;
    logic [11:0]       r_temp, n_temp;
    logic [11:0]       r_start, n_start;
    logic [ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic [QW-1:0]     r_acc_q, n_acc_q;
    logic [RW-1:0]     r_acc_r, n_acc_r;
    logic [11:0]       r_sp, n_sp;
    logic              r_heater, n_heater;
    logic              snap_load;
    t_step             r_snap [MAX_MANUAL_STEPS];

    logic              r_out_valid;
    logic [31:0]       r_out_data;

    logic              proceed;
    t_step             cur;
    logic [2:0]        man_len;
    logic [11:0]       temp_new;
    logic [2:0]        step_inc;
    logic              last_step;
    logic              el_inc;
    logic [RW:0]       r_sum;
    logic              carry;
    logic [QW:0]       q_sum;
    logic [QW-1:0]     q_new;
    logic [HW-1:0]     hold_ticks;
    logic              reached;
    logic              near;
    logic              fin;
    logic              go_next;

    assign proceed       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || proceed;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_req    <= s_axis_tuser;
            r_in_sample <= s_axis_tdata[11:0];
            r_in_sv     <= s_axis_tdata[12];
            r_in_man    <= s_axis_tdata[13];
            r_in_auto   <= s_axis_tdata[14];
        end
    end

    // Active step: snapshot of the manual table, or the preset
    always_comb begin
        cur = '0;
        if (r_man) begin
            for (int i = 0; i < MAX_MANUAL_STEPS; i++) begin
                if (r_step == 3'(i)) begin
                    cur = r_snap[i];
                end
            end
        end else begin
            cur = preset_step(r_step);
        end
    end

    assign man_len   = (cfg.count > MAX_W) ? MAX_W : cfg.count;
    assign temp_new  = ((r_in_req == REQ_TICK || r_in_req == REQ_START) && r_in_sv)
                       ? r_in_sample : r_temp;
    assign step_inc  = r_step + 3'd1;
    assign last_step = (step_inc >= r_len);
    assign el_inc    = (r_elapsed != ELAPSED_MAX);

    // Running ramp offset: one more rate per tick, folded by DIV
    assign r_sum = {1'b0, r_acc_r} + {1'b0, rate_r_tbl[cur.rate]};
    assign carry = (r_sum >= DIV_W);
    assign q_sum = {1'b0, r_acc_q} + (QW + 1)'(rate_q_tbl[cur.rate]) + (QW + 1)'(carry);
    assign q_new = (q_sum > Q_SAT) ? Q_SAT[QW-1:0] : q_sum[QW-1:0];

    assign hold_ticks = HW'(cur.hold) * HW'(TPS_V);

    always_comb begin
        n_phase   = r_phase;
        n_step    = r_step;
        n_len     = r_len;
        n_man     = r_man;
        n_auto    = r_auto;
        n_temp    = r_temp;
        n_start   = r_start;
        n_elapsed = r_elapsed;
        n_acc_q   = r_acc_q;
        n_acc_r   = r_acc_r;
        n_sp      = r_sp;
        n_heater  = r_heater;
        snap_load = 1'b0;
        reached   = 1'b0;
        near      = 1'b0;
        fin       = 1'b0;
        go_next   = 1'b0;

        case (r_in_req)
            REQ_TICK: begin
                n_temp = temp_new;
                if (el_inc) begin
                    n_elapsed = r_elapsed + ELAPSED_W'(1);
                end
                case (r_phase)
                    PH_RAMP: begin
                        if (el_inc) begin
                            n_acc_q = q_new;
                            n_acc_r = carry ? RW'(r_sum - DIV_W) : r_sum[RW-1:0];
                        end
                        if (cur.target > r_start) begin
                            reached = ((QW + 1)'(r_start) + (QW + 1)'(n_acc_q))
                                      >= (QW + 1)'(cur.target);
                            n_sp    = reached ? cur.target : r_start + n_acc_q[11:0];
                        end else begin
                            reached = (n_acc_q >= QW'(r_start - cur.target));
                            n_sp    = reached ? cur.target : r_start - n_acc_q[11:0];
                        end
                        near = (temp_new >= cur.target) ? (temp_new - cur.target < 12'd8)
                                                        : (cur.target - temp_new < 12'd8);
                        if (reached && near) begin
                            if (cur.hold != 16'd0) begin
                                n_phase   = PH_HOLD;
                                n_elapsed = '0;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                    end
                    PH_HOLD: begin
                        n_sp = cur.target;
                        fin  = (CW'(n_elapsed) >= CW'(hold_ticks));
                    end
                    PH_WAIT: begin
                        n_sp = cur.target;
                    end
                    default: begin
                        n_heater = 1'b0;
                        n_sp     = '0;
                    end
                endcase
                if (fin) begin
                    if (r_auto) begin
                        go_next = 1'b1;
                    end else begin
                        n_phase = PH_WAIT;
                    end
                end
            end
            REQ_START: begin
                n_temp = temp_new;
                if (!(r_in_man && man_len == 3'd0)) begin
                    snap_load = r_in_man;
                    n_len     = r_in_man ? man_len : PRESET_LEN;
                    n_man     = r_in_man;
                    n_auto    = r_in_auto;
                    n_step    = '0;
                    n_start   = temp_new;
                    n_elapsed = '0;
                    n_acc_q   = '0;
                    n_acc_r   = '0;
                    n_phase   = PH_RAMP;
                end
            end
            REQ_ADVANCE: begin
                go_next = (r_phase != PH_IDLE);
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        if (go_next) begin
            n_step = step_inc;
            if (last_step) begin
                n_phase  = PH_IDLE;
                n_heater = 1'b0;
                n_sp     = '0;
            end else begin
                n_start   = temp_new;
                n_elapsed = '0;
                n_acc_q   = '0;
                n_acc_r   = '0;
                n_phase   = PH_RAMP;
            end
        end

        // On/off rule; on an advancing tick it still sees the old setpoint
        if (r_in_req == REQ_TICK && n_phase != PH_IDLE) begin
            if ({1'b0, temp_new} + 13'd4 < {1'b0, n_sp}) begin
                n_heater = 1'b1;
            end else if ({1'b0, temp_new} > {1'b0, n_sp} + 13'd2) begin
                n_heater = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_step      <= '0;
            r_len       <= '0;
            r_man       <= 1'b0;
            r_auto      <= 1'b0;
            r_temp      <= '0;
            r_start     <= '0;
            r_elapsed   <= '0;
            r_acc_q     <= '0;
            r_acc_r     <= '0;
            r_sp        <= '0;
            r_heater    <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_data  <= '0;
        end else begin
            if (proceed) begin
                r_phase    <= n_phase;
                r_step     <= n_step;
                r_len      <= n_len;
                r_man      <= n_man;
                r_auto     <= n_auto;
                r_temp     <= n_temp;
                r_start    <= n_start;
                r_elapsed  <= n_elapsed;
                r_acc_q    <= n_acc_q;
                r_acc_r    <= n_acc_r;
                r_sp       <= n_sp;
                r_heater   <= n_heater;
                r_out_data <= {2'b00, n_temp, n_step, 2'(n_phase), n_sp, n_heater};
            end
            if (proceed) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (proceed && snap_load) begin
            for (int i = 0; i < MAX_MANUAL_STEPS; i++) begin
                r_snap[i] <= cfg.step[i];
            end
        end
    end

endmodule

>>> rtl/rps_cfg_regs.sv
// ----------------------------------------------------------------------------
// rps_cfg_regs
// APB register file: six manual step registers and the manual step count.
// ----------------------------------------------------------------------------
module rps_cfg_regs import rps_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic                  pready,
    output logic [CFG_DATA_W-1:0] prdata,
    output t_cfg                  o_cfg
);

    localparam t_cfg CFG_RST = {COUNT_RST, {(NUM_CFG_STEPS-2){36'd0}}, STEP1_RST, STEP0_RST};

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[CFG_ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RST;
        end else if (wr_en) begin
            for (int i = 0; i < NUM_CFG_STEPS; i++) begin
                if (reg_idx == 3'(i)) begin
                    r_cfg.step[i] <= pwdata[35:0];
                end
            end
            if (reg_idx == REG_STEP_COUNT) begin
                r_cfg.count <= pwdata[2:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        for (int i = 0; i < NUM_CFG_STEPS; i++) begin
            if (reg_idx == 3'(i)) begin
                prdata = CFG_DATA_W'(r_cfg.step[i]);
            end
        end
        if (reg_idx == REG_STEP_COUNT) begin
            prdata = CFG_DATA_W'(r_cfg.count);
        end
    end

endmodule
